// File: rtl/tspg_pkg.sv
package tspg_pkg;

    // Table geometry and number formats.
    localparam int GROUP_COUNT       = 8;
    localparam int SAMPLES_PER_GROUP = 16;
    localparam int FRAC_BITS         = 32;
    localparam int IDX_W             = 32;
    localparam int GID_W             = 32;
    localparam int WSLOT_W           = 4;
    localparam int COORD_W           = 32;
    localparam int OUT_W             = FRAC_BITS + 1;

    localparam int DEPTH   = GROUP_COUNT * SAMPLES_PER_GROUP;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GROUP_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int SLOT_W  = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;

    // First index of level s: SAMPLES_PER_GROUP * (1 + 4 + ... + 4^(s-1)).
    function automatic logic [63:0] level_start(input int s);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = '0;
        sq  = 64'd1;
        for (int k = 0; k < s; k++) begin
            acc = acc + sq * 64'(SAMPLES_PER_GROUP);
            sq  = sq << 2;
        end
        return acc;
    endfunction

    // Deepest level whose first index still fits in a sample index.
    function automatic int level_limit();
        int n;
        n = 0;
        for (int k = 1; k <= 20; k++) begin
            if (level_start(k) <= ((64'd1 << IDX_W) - 64'd1)) begin
                n = k;
            end
        end
        return n;
    endfunction

    localparam int LEVEL_MAX = level_limit();
    localparam int LEVEL_W   = $clog2(LEVEL_MAX + 1);
    localparam int TILE_W    = (LEVEL_MAX > 0) ? LEVEL_MAX : 1;

    // Orientation codes.
    localparam logic [2:0] ORI_IDENT     = 3'd0;
    localparam logic [2:0] ORI_ROT90     = 3'd1;
    localparam logic [2:0] ORI_ROT180    = 3'd2;
    localparam logic [2:0] ORI_ROT270    = 3'd3;
    localparam logic [2:0] ORI_FLIP_X    = 3'd4;
    localparam logic [2:0] ORI_SWAP      = 3'd5;
    localparam logic [2:0] ORI_FLIP_Y    = 3'd6;
    localparam logic [2:0] ORI_ANTI_SWAP = 3'd7;

    // Item modes.
    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    // Level of a sample index and its offset within that level.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [IDX_W-1:0]   rem;
    } t_locate;

    // Table entry for a group and a slot within it.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [GROUP_W-1:0] grp,
                                                     input logic [SLOT_W-1:0]  slot);
        logic [31:0] full;
        full = 32'(grp) * 32'(SAMPLES_PER_GROUP) + 32'(slot);
        return full[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/tspg_locate.sv
module tspg_locate (
    input  logic [tspg_pkg::IDX_W-1:0] i_sample_index,
    output tspg_pkg::t_locate          o_loc
);
    import tspg_pkg::*;

    logic [LEVEL_W-1:0] level;
    logic [IDX_W-1:0]   start;

    // Levels are found by comparing against every level start in parallel;
    // the number of starts passed is the level.
    always_comb begin
        level = '0;
        for (int k = 1; k <= LEVEL_MAX; k++) begin
            if (i_sample_index >= IDX_W'(level_start(k))) begin
                level = level + LEVEL_W'(1);
            end
        end
    end

    // Pick the start of the found level and take the offset from it.
    always_comb begin
        start = '0;
        for (int k = 1; k <= LEVEL_MAX; k++) begin
            if (level == LEVEL_W'(k)) begin
                start = IDX_W'(level_start(k));
            end
        end
    end

    assign o_loc.level = level;
    assign o_loc.rem   = i_sample_index - start;

endmodule

// File: rtl/tspg_transform.sv
module tspg_transform (
    input  logic [tspg_pkg::FRAC_BITS-1:0] i_base_x,
    input  logic [tspg_pkg::FRAC_BITS-1:0] i_base_y,
    input  logic [tspg_pkg::TILE_W-1:0]    i_tile_x,
    input  logic [tspg_pkg::TILE_W-1:0]    i_tile_y,
    input  logic [tspg_pkg::LEVEL_W-1:0]   i_level,
    input  logic [2:0]                     i_orientation,
    output logic [tspg_pkg::OUT_W-1:0]     o_point_x,
    output logic [tspg_pkg::OUT_W-1:0]     o_point_y
);
    import tspg_pkg::*;

    localparam logic [OUT_W-1:0] ONE_FIXED = OUT_W'(1) << FRAC_BITS;

    logic [FRAC_BITS-1:0] sx;
    logic [FRAC_BITS-1:0] sy;
    logic [OUT_W-1:0]     px;
    logic [OUT_W-1:0]     py;
    logic [OUT_W-1:0]     nx;
    logic [OUT_W-1:0]     ny;

    // Scale (tile + base) by one over the side; the tile sits above the
    // fraction bits, so both parts shift right by the level.
    assign sx = FRAC_BITS'({i_tile_x, FRAC_BITS'(0)} >> i_level) + (i_base_x >> i_level);
    assign sy = FRAC_BITS'({i_tile_y, FRAC_BITS'(0)} >> i_level) + (i_base_y >> i_level);

    assign px = {1'b0, sx};
    assign py = {1'b0, sy};
    assign nx = ONE_FIXED - px;
    assign ny = ONE_FIXED - py;

    // Apply one of the eight symmetries of the unit square.
    always_comb begin
        case (i_orientation)
            ORI_IDENT:     begin o_point_x = px; o_point_y = py; end
            ORI_ROT90:     begin o_point_x = ny; o_point_y = px; end
            ORI_ROT180:    begin o_point_x = nx; o_point_y = ny; end
            ORI_ROT270:    begin o_point_x = py; o_point_y = nx; end
            ORI_FLIP_X:    begin o_point_x = nx; o_point_y = py; end
            ORI_SWAP:      begin o_point_x = py; o_point_y = px; end
            ORI_FLIP_Y:    begin o_point_x = px; o_point_y = ny; end
            default:       begin o_point_x = ny; o_point_y = nx; end
        endcase
    end

endmodule

// File: rtl/tiled_sample_pattern_generator.sv
// Tiled sample pattern generator. Load transactions (mode 1) write one base
// point into the pattern table and give no result; query transactions (mode 0)
// give one point with 32 fraction bits. The block takes one transaction per
// cycle while the output is not stalled. A query's level is found while the
// transaction is offered and registered as it is accepted in stage 1, stage 2
// registers the table read, and the point is scaled and oriented into the
// output register. All transactions reach the table in order, so a query sees
// every load accepted before it. A stall on the output holds the whole
// pipeline and is passed to the input.
module tiled_sample_pattern_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [tspg_pkg::IDX_W-1:0]      i_sample_index,
    input  logic [2:0]                      i_orientation,
    input  logic [tspg_pkg::GID_W-1:0]      i_group_id,
    input  logic [tspg_pkg::WSLOT_W-1:0]    i_write_slot,
    input  logic [tspg_pkg::COORD_W-1:0]    i_write_x,
    input  logic [tspg_pkg::COORD_W-1:0]    i_write_y,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tspg_pkg::OUT_W-1:0]      o_point_x,
    output logic [tspg_pkg::OUT_W-1:0]      o_point_y
);
    import tspg_pkg::*;

    logic advance;
    logic in_accept;
    logic slot_ok;

    t_locate loc;

    // Stage 1: level and offset.
    logic                   r_s1_valid;
    logic                   r_s1_load;
    logic [LEVEL_W-1:0]     r_s1_level;
    logic [IDX_W-1:0]       r_s1_rem;
    logic [2:0]             r_s1_orient;
    logic [GROUP_W-1:0]     r_s1_group;
    logic [SLOT_W-1:0]      r_s1_wslot;
    logic [FRAC_BITS-1:0]   r_s1_wx;
    logic [FRAC_BITS-1:0]   r_s1_wy;

    // Stage 2: table access.
    logic                   r_s2_valid;
    logic [LEVEL_W-1:0]     r_s2_level;
    logic [TILE_W-1:0]      r_s2_tx;
    logic [TILE_W-1:0]      r_s2_ty;
    logic [2:0]             r_s2_orient;
    logic [2*FRAC_BITS-1:0] r_rd_data;
    logic [2*FRAC_BITS-1:0] r_table [DEPTH];

    // Output register.
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_x;
    logic [OUT_W-1:0]       r_out_y;

    logic [TILE_W-1:0]      tile_mask;
    logic [TILE_W-1:0]      tx;
    logic [TILE_W-1:0]      ty;
    logic [SLOT_W-1:0]      rd_slot;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [OUT_W-1:0]       n_out_x;
    logic [OUT_W-1:0]       n_out_y;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;
    assign in_accept  = i_in_valid && advance;
    assign slot_ok    = int'(i_write_slot) < SAMPLES_PER_GROUP;

    tspg_locate u_locate (
        .i_sample_index (i_sample_index),
        .o_loc          (loc)
    );

    // Stage 1 control; loads to a slot past the group are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= in_accept && (i_mode == MODE_QUERY || slot_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_load   <= i_mode == MODE_LOAD;
            r_s1_level  <= loc.level;
            r_s1_rem    <= loc.rem;
            r_s1_orient <= i_orientation;
            r_s1_group  <= i_group_id[GROUP_W-1:0] & GROUP_W'(GROUP_COUNT - 1);
            r_s1_wslot  <= i_write_slot[SLOT_W-1:0];
            r_s1_wx     <= i_write_x[FRAC_BITS-1:0];
            r_s1_wy     <= i_write_y[FRAC_BITS-1:0];
        end
    end

    // Split the offset into tile x, tile y and base slot; the side is 2^level.
    assign tile_mask = ~({TILE_W{1'b1}} << r_s1_level);
    assign tx        = r_s1_rem[TILE_W-1:0] & tile_mask;
    assign ty        = TILE_W'(r_s1_rem >> r_s1_level) & tile_mask;
    assign rd_slot   = SLOT_W'(r_s1_rem >> {r_s1_level, 1'b0});
    assign rd_addr   = entry_addr(r_s1_group, rd_slot);
    assign wr_addr   = entry_addr(r_s1_group, r_s1_wslot);

    // Pattern table: loads write, queries read, one access per cycle in order while the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            if (r_s1_load) begin
                r_table[wr_addr] <= {r_s1_wy, r_s1_wx};
            end else begin
                r_rd_data <= r_table[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid && !r_s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_level  <= r_s1_level;
            r_s2_tx     <= tx;
            r_s2_ty     <= ty;
            r_s2_orient <= r_s1_orient;
        end
    end

    tspg_transform u_transform (
        .i_base_x      (r_rd_data[FRAC_BITS-1:0]),
        .i_base_y      (r_rd_data[2*FRAC_BITS-1:FRAC_BITS]),
        .i_tile_x      (r_s2_tx),
        .i_tile_y      (r_s2_ty),
        .i_level       (r_s2_level),
        .i_orientation (r_s2_orient),
        .o_point_x     (n_out_x),
        .o_point_y     (n_out_y)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;

endmodule

// File: dv/tb.sv
module tb;
    import tspg_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // One pending input transaction; hold_off makes the driver wait for an empty
    // result queue before it offers this transaction.
    typedef struct packed {
        logic                 mode;
        logic [IDX_W-1:0]     sample_index;
        logic [2:0]           orientation;
        logic [GID_W-1:0]     group_id;
        logic [WSLOT_W-1:0]   write_slot;
        logic [COORD_W-1:0]   write_x;
        logic [COORD_W-1:0]   write_y;
        logic                 hold_off;
    } t_sample_req;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } t_point;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode = MODE_QUERY;
    logic [IDX_W-1:0]     i_sample_index = '0;
    logic [2:0]           i_orientation = ORI_IDENT;
    logic [GID_W-1:0]     i_group_id = '0;
    logic [WSLOT_W-1:0]   i_write_slot = '0;
    logic [COORD_W-1:0]   i_write_x = '0;
    logic [COORD_W-1:0]   i_write_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OUT_W-1:0]     o_point_x;
    logic [OUT_W-1:0]     o_point_y;

    t_sample_req          pending_items[$];
    t_point               expected_points[$];
    t_sample_req          next_req;
    t_point               exp_pt;

    // Shadow of the pattern table, and which entries the stimulus has loaded.
    logic [FRAC_BITS-1:0] table_x [DEPTH];
    logic [FRAC_BITS-1:0] table_y [DEPTH];
    bit                   loaded_entry [DEPTH];

    int                   n_accepted = 0;
    int                   n_shown = 0;
    int                   cycle_count = 0;
    int                   fail_count = 0;
    bit                   next_hold = 1'b0;
    logic                 calm;

    tiled_sample_pattern_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_sample_index (i_sample_index),
        .i_orientation  (i_orientation),
        .i_group_id     (i_group_id),
        .i_write_slot   (i_write_slot),
        .i_write_x      (i_write_x),
        .i_write_y      (i_write_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y)
    );

    // No random idling on either side during this stretch of transactions.
    assign calm = (n_accepted >= 400) && (n_accepted < 560);

    function automatic int group_of(input logic [GID_W-1:0] gid);
        return int'((gid & 32'(GROUP_COUNT - 1)) % 32'(GROUP_COUNT));
    endfunction

    // Walk the levels: level k holds side*side*SAMPLES_PER_GROUP indices.
    function automatic void locate_sample(input logic [IDX_W-1:0] idx, output int lvl,
                                          output logic [63:0] tx, output logic [63:0] ty,
                                          output int slot);
        logic [63:0] rem;
        logic [63:0] side;
        rem  = 64'(idx);
        side = 64'd1;
        lvl  = 0;
        while (rem >= side * side * 64'(SAMPLES_PER_GROUP)) begin
            rem  = rem - side * side * 64'(SAMPLES_PER_GROUP);
            side = side << 1;
            lvl++;
        end
        tx   = rem % side;
        ty   = (rem / side) % side;
        slot = int'(rem / (side * side));
    endfunction

    // Floor of (tile + base) / 2^lvl with base in fixed point.
    function automatic logic [63:0] tile_scale(input logic [63:0] tile, input logic [63:0] base,
                                               input int lvl);
        if (lvl <= FRAC_BITS) begin
            return (tile << (FRAC_BITS - lvl)) + (base >> lvl);
        end
        return tile >> (lvl - FRAC_BITS);
    endfunction

    function automatic t_point predict_point(input logic [IDX_W-1:0] idx,
                                             input logic [2:0] ori,
                                             input logic [GID_W-1:0] gid);
        int          lvl;
        int          slot;
        int          e;
        logic [63:0] tx;
        logic [63:0] ty;
        logic [63:0] px;
        logic [63:0] py;
        logic [63:0] nx;
        logic [63:0] ny;
        logic [63:0] rx;
        logic [63:0] ry;
        t_point      p;
        locate_sample(idx, lvl, tx, ty, slot);
        e  = group_of(gid) * SAMPLES_PER_GROUP + slot;
        px = tile_scale(tx, 64'(table_x[e]), lvl);
        py = tile_scale(ty, 64'(table_y[e]), lvl);
        nx = (64'd1 << FRAC_BITS) - px;
        ny = (64'd1 << FRAC_BITS) - py;
        case (ori)
            ORI_IDENT: begin
                rx = px; ry = py;
            end
            ORI_ROT90: begin
                rx = ny; ry = px;
            end
            ORI_ROT180: begin
                rx = nx; ry = ny;
            end
            ORI_ROT270: begin
                rx = py; ry = nx;
            end
            ORI_FLIP_X: begin
                rx = nx; ry = py;
            end
            ORI_SWAP: begin
                rx = py; ry = px;
            end
            ORI_FLIP_Y: begin
                rx = px; ry = ny;
            end
            default: begin
                rx = ny; ry = nx;
            end
        endcase
        p.x = rx[OUT_W-1:0];
        p.y = ry[OUT_W-1:0];
        return p;
    endfunction

    // Random coordinate with the extremes mixed in.
    function automatic logic [COORD_W-1:0] pick_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 10) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic add_load(input logic [GID_W-1:0] gid, input logic [WSLOT_W-1:0] slot,
                            input logic [COORD_W-1:0] wx, input logic [COORD_W-1:0] wy);
        t_sample_req req;
        req.mode         = MODE_LOAD;
        req.sample_index = $urandom;
        req.orientation  = 3'($urandom_range(7));
        req.group_id     = gid;
        req.write_slot   = slot;
        req.write_x      = wx;
        req.write_y      = wy;
        req.hold_off     = next_hold;
        next_hold        = 1'b0;
        if (int'(slot) < SAMPLES_PER_GROUP) begin
            loaded_entry[group_of(gid) * SAMPLES_PER_GROUP + int'(slot)] = 1'b1;
        end
        pending_items.push_back(req);
    endtask

    task automatic add_query(input logic [IDX_W-1:0] idx, input logic [2:0] ori,
                             input logic [GID_W-1:0] gid);
        t_sample_req req;
        req.mode         = MODE_QUERY;
        req.sample_index = idx;
        req.orientation  = ori;
        req.group_id     = gid;
        req.write_slot   = 4'($urandom_range(15));
        req.write_x      = $urandom;
        req.write_y      = $urandom;
        req.hold_off     = next_hold;
        next_hold        = 1'b0;
        pending_items.push_back(req);
    endtask

    // Clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Reset is released at a falling edge.
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Input driver: offers the head of the pending queue and holds it until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (n_accepted == n_shown) begin
            if (pending_items.size() != 0) begin
                next_req = pending_items[0];
                if ((next_req.hold_off && expected_points.size() != 0) ||
                    (!calm && $urandom_range(99) < 24)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_mode         <= next_req.mode;
                    i_sample_index <= next_req.sample_index;
                    i_orientation  <= next_req.orientation;
                    i_group_id     <= next_req.group_id;
                    i_write_slot   <= next_req.write_slot;
                    i_write_x      <= next_req.write_x;
                    i_write_y      <= next_req.write_y;
                    i_in_valid     <= 1'b1;
                    n_shown++;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    // Monitor: check each result transaction, then predict for each input transaction.
    always @(posedge i_clk) begin
        int e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** tiled_sample_pattern_generator: FAILED **");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected result: point_x %h point_y %h", o_point_x, o_point_y);
                    fail_count++;
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (o_point_x !== exp_pt.x) begin
                        $error("point_x: expected %h, got %h", exp_pt.x, o_point_x);
                        fail_count++;
                    end
                    if (o_point_y !== exp_pt.y) begin
                        $error("point_y: expected %h, got %h", exp_pt.y, o_point_y);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                if (i_mode == MODE_LOAD) begin
                    if (int'(i_write_slot) < SAMPLES_PER_GROUP) begin
                        e = group_of(i_group_id) * SAMPLES_PER_GROUP + int'(i_write_slot);
                        table_x[e] = i_write_x[FRAC_BITS-1:0];
                        table_y[e] = i_write_y[FRAC_BITS-1:0];
                    end
                end else begin
                    expected_points.push_back(
                        predict_point(i_sample_index, i_orientation, i_group_id));
                end
                pending_items.delete(0);
                n_accepted++;
            end
        end
    end

    // Stimulus and end of test.
    initial begin
        int          roll;
        int          lvl;
        int          slot;
        int          g0;
        int          found;
        int          g;
        logic [63:0] tx;
        logic [63:0] ty;
        logic [63:0] start;
        logic [63:0] sq;
        logic [63:0] side;
        logic [63:0] wide;
        logic [IDX_W-1:0] qidx;

        for (int k = 0; k < DEPTH; k++) begin
            loaded_entry[k] = 1'b0;
        end

        // Directed: zero and all-ones base points, all orientations on a zero point.
        add_load(32'h0000_0000, 4'd0, 32'h0000_0000, 32'h0000_0000);
        add_load(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_load(32'h0ABC_DEF3, 4'd10, 32'h89AB_CDEF, 32'h0123_4567);
        for (int o = 0; o < 8; o++) begin
            add_query(32'd0, 3'(o), 32'h0000_0000);
        end
        // Last base index, first and last index of level one.
        add_query(32'd15, ORI_ANTI_SWAP, 32'h7FFF_FFF7);
        add_query(32'd16, ORI_IDENT, 32'h0000_0000);
        add_query(32'd79, ORI_ROT180, 32'hFFFF_FFFF);
        // Largest index, last index of level 13 and first of the deepest level.
        add_query(32'hFFFF_FFFF, ORI_SWAP, 32'h0ABC_DEF3);
        add_query(32'd1431655759, ORI_FLIP_X, 32'h0000_0007);
        add_query(32'd1431655760, ORI_ROT270, 32'h0000_0000);
        // A load directly followed by a query of the same entry, upper group bits set.
        add_load(32'h0000_0008, 4'd0, 32'h0000_0001, 32'hFFFF_FFFE);
        add_query(32'd0, ORI_ROT90, 32'h8000_0008);
        add_query(32'd0, ORI_FLIP_Y, 32'h0000_0000);

        // Random part; pause for an empty result queue at its start and midway.
        next_hold = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 450) begin
                next_hold = 1'b1;
            end
            if ($urandom_range(99) < 30) begin
                add_load($urandom, 4'($urandom_range(15)), pick_coord(), pick_coord());
            end else begin
                roll = $urandom_range(99);
                if (roll < 25) begin
                    qidx = $urandom_range(SAMPLES_PER_GROUP - 1);
                end else if (roll < 65) begin
                    // Build an index from a level, a slot and a tile.
                    lvl   = $urandom_range(1) ? $urandom_range(3, 1) : $urandom_range(14, 4);
                    start = 64'd0;
                    sq    = 64'd1;
                    for (int k = 0; k < lvl; k++) begin
                        start = start + sq * 64'(SAMPLES_PER_GROUP);
                        sq    = sq << 2;
                    end
                    side = 64'd1 << lvl;
                    wide = start + 64'($urandom_range(SAMPLES_PER_GROUP - 1)) * sq
                         + 64'($urandom_range(side - 1)) * side
                         + 64'($urandom_range(side - 1));
                    qidx = (wide[63:IDX_W] == '0) ? wide[IDX_W-1:0] : $urandom;
                end else begin
                    qidx = $urandom;
                end
                // Only query entries that were loaded; otherwise load that slot.
                locate_sample(qidx, lvl, tx, ty, slot);
                g0    = $urandom_range(GROUP_COUNT - 1);
                found = -1;
                for (int k = 0; k < GROUP_COUNT; k++) begin
                    g = (g0 + k) % GROUP_COUNT;
                    if (found < 0 && loaded_entry[g * SAMPLES_PER_GROUP + slot]) begin
                        found = g;
                    end
                end
                if (found >= 0) begin
                    add_query(qidx, 3'($urandom_range(7)),
                              ($urandom & ~32'(GROUP_COUNT - 1)) | 32'(found));
                end else begin
                    add_load($urandom, 4'(slot), pick_coord(), pick_coord());
                end
            end
        end

        while (pending_items.size() != 0 || expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_points.size() == 0) begin
            $display("** tiled_sample_pattern_generator: PASSED **");
        end else begin
            $display("** tiled_sample_pattern_generator: FAILED **");
        end
        $finish;
    end

endmodule
